FILE: rtl/iida_pkg.sv
// ----------------------------------------------------------------------------
// iida_pkg: shared types and codes for the indexed insert/delete array
// Item layouts, operation and status codes, and the per-cell command.
// ----------------------------------------------------------------------------
package iida_pkg;

  localparam int IDX_W   = 6;
  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;   // insert that succeeds this cycle
    logic                     del;   // delete that succeeds this cycle
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

FILE: rtl/iida_cell.sv
// ----------------------------------------------------------------------------
// iida_cell: one storage cell of the shifting row
// Holds one word; each cycle holds, takes a neighbor or takes the new word.
// ----------------------------------------------------------------------------
module iida_cell #(
  parameter int POS = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iida_pkg::cell_cmd_t                 cmd,
  input  logic signed [iida_pkg::WORD_W-1:0]  left_word,
  input  logic signed [iida_pkg::WORD_W-1:0]  right_word,
  output logic signed [iida_pkg::WORD_W-1:0]  word,
  output logic                                sel
);
  import iida_pkg::*;

  localparam logic [31:0] POS_U = 32'(POS);

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;
  logic [31:0]              idx_u;

  assign idx_u = 32'(cmd.idx);
  assign sel   = (idx_u == POS_U);

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (idx_u == POS_U) begin
        word_nxt = cmd.word;
      end else if (POS_U > idx_u) begin
        word_nxt = left_word;
      end
    end else if (cmd.del && (POS_U >= idx_u)) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

FILE: rtl/indexed_insert_delete_array.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_array: ordered word array with insert/delete at index
// A row of shifting cells plus a fill count; one result per input item.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY signed 32-bit words in order, with a fill
// count. Each input item reads, inserts or deletes at an index; every item
// yields exactly one result with the read word (zero unless a read succeeds),
// a status (ok, index out of range, array full) and the count after the item.
// An item is accepted, all cells shift or hold at the same edge, and the
// result lands in the output register. One item per cycle is sustained as
// long as the result side takes results; a new item is accepted whenever
// the output register is empty or is being emptied. The rate is set by the
// cell row, where every cell picks its next word locally. Reset clears every
// cell and the count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iida_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iida_pkg::out_item_t   out_data
);
  import iida_pkg::*;

  // Count width holds 0..CAPACITY; compares run at the wider of count and index
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int OW = (XW > COUNT_W) ? XW : COUNT_W;

  logic [CW-1:0]            fill_count_r;
  logic [CW-1:0]            fill_count_nxt;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic                     acc;
  logic [XW-1:0]            idx_x;
  logic [XW-1:0]            cnt_x;
  logic                     below_cnt;
  logic                     full;
  logic                     ins_ok;
  logic                     del_ok;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] rd_word;
  logic [OW-1:0]            cnt_wide;
  cell_cmd_t                cmd;

  logic signed [WORD_W-1:0] cell_word [CAPACITY];
  logic                     cell_sel  [CAPACITY];

  // Handshake: accept while the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  // Decode the item against the current count
  assign idx_x     = XW'(in_data.index);
  assign cnt_x     = XW'(fill_count_r);
  assign below_cnt = (idx_x < cnt_x);
  assign full      = (cnt_x == XW'(CAPACITY));

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    status = ST_RANGE;
    case (in_data.op)
      OP_READ: begin
        if (below_cnt) begin
          status = ST_OK;
        end
      end
      OP_INSERT: begin
        if (idx_x > cnt_x) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
          ins_ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (below_cnt) begin
          status = ST_OK;
          del_ok = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // Broadcast the command; cells only move on an accepted, successful item
  assign cmd.ins  = acc && ins_ok;
  assign cmd.del  = acc && del_ok;
  assign cmd.idx  = in_data.index;
  assign cmd.word = in_data.new_value;

  // Row of cells: each takes from its left neighbor on insert and its right
  // neighbor on delete; the ends see zero. Cells above the count stay zero.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    iida_cell #(
      .POS (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g]),
      .sel        (cell_sel[g])
    );
  end

  // Read: the one selected cell drives its word onto an OR bus
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | (cell_word[i] & {WORD_W{cell_sel[i]}});
    end
  end

  // Advance the count
  always_comb begin
    fill_count_nxt = fill_count_r;
    if (cmd.ins) begin
      fill_count_nxt = fill_count_r + 1'b1;
    end else if (cmd.del) begin
      fill_count_nxt = fill_count_r - 1'b1;
    end
  end

  assign cnt_wide = OW'(fill_count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_count_r <= fill_count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r.read_value <= ((in_data.op == OP_READ) && below_cnt) ? rd_word : '0;
      out_data_r.status     <= status;
      out_data_r.count      <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(fill_count_r) <= XW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_ins_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (fill_count_r == $past(fill_count_r) + 1'b1))
    else $error("insert did not advance the count");

  a_del_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del |=> (fill_count_r == $past(fill_count_r) - 1'b1))
    else $error("delete did not drop the count");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (status == ST_FULL)) |=> (XW'(fill_count_r) == XW'(CAPACITY)))
    else $error("full status below capacity");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.read_value == '0))
    else $error("nonzero read word on failed item");
`endif

endmodule
